### hdl/grid_ray_march_column_defines.svh
// Assertion macros for the grid ray march column block.
// Used by the top level only; expects clk and arst_n in the including scope.
`ifndef GRID_RAY_MARCH_COLUMN_DEFINES_SVH
`define GRID_RAY_MARCH_COLUMN_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GRMC_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("grmc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GRMC_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("grmc: next-cycle check failed");

`endif

### hdl/grmc_pkg.sv
// Shared types, constants and tables of the grid ray march column block.
// No dependencies; imported by every module of the block.
`default_nettype none

package grmc_pkg;

	// Fixed geometry of the block.
	localparam int SCREEN_ROWS    = 24;
	localparam int HALF_ROWS      = SCREEN_ROWS / 2;
	localparam int MAP_DIM        = 10;
	localparam int MAP_BITS       = MAP_DIM * MAP_DIM;
	localparam int STEPS_PER_CELL = 64;
	localparam int UNIT_SHIFT     = 16 + $clog2(STEPS_PER_CELL);
	localparam int POS_SHIFT      = UNIT_SHIFT - 12;

	// Angle constants in 1/128 degree units.
	localparam int FULL_TURN    = 46080;
	localparam int QUARTER_TURN = 11520;
	localparam int CORDIC_X0    = 39797;
	localparam int CORDIC_ITERS = 16;

	// Internal widths.
	localparam int AW = 21;   // unreduced angle sum
	localparam int CW = 20;   // rotator x and y
	localparam int ZW = 24;   // rotator residual angle
	localparam int PW = 29;   // ray position, signed
	localparam int DW = 26;   // displacement magnitude
	localparam int SW = 2 * DW + 1; // squared distance
	localparam int HW = $clog2(HALF_ROWS + 1);
	localparam int RW = 5;
	localparam int QUEUE_DEPTH = 2;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_MAP_LOW   = 2'd0;
	localparam logic [1:0] REG_MAP_HIGH  = 2'd1;
	localparam logic [1:0] REG_HALF_FOV  = 2'd2;
	localparam logic [1:0] REG_ANGLE_STEP = 2'd3;

	// Squared distance limits: height h+1 fits when distance squared is at most
	// HGT_THR[h].
	localparam logic [SW-1:0] DIST_NUM = SW'(HALF_ROWS * HALF_ROWS) << (2 * UNIT_SHIFT);
	localparam logic [SW-1:0] HGT_THR [HALF_ROWS] = '{
		DIST_NUM / 1,  DIST_NUM / 4,  DIST_NUM / 9,   DIST_NUM / 16,
		DIST_NUM / 25, DIST_NUM / 36, DIST_NUM / 49,  DIST_NUM / 64,
		DIST_NUM / 81, DIST_NUM / 100, DIST_NUM / 121, DIST_NUM / 144
	};

	typedef enum logic [1:0] {
		KIND_SKY   = 2'd0,
		KIND_WALL  = 2'd1,
		KIND_FLOOR = 2'd2
	} kind_t;

	typedef struct packed {
		logic [6:0]  column;
		logic [15:0] view_angle;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
	} in_t;

	typedef struct packed {
		logic [6:0] out_column;
		logic [4:0] row;
		kind_t      cell_kind;
		logic       last_row;
		logic       fault;
	} out_t;

	// Configuration seen by the front end.
	typedef struct packed {
		logic [MAP_BITS-1:0] map_bits;
		logic [14:0]         half_fov;
		logic [12:0]         angle_step;
	} cfg_t;

	// Per-column result passed from front end to back end.
	typedef struct packed {
		logic [6:0]    column;
		logic [HW-1:0] height;
		logic          fault;
	} col_res_t;

	// Arctangent table of the rotator, in 1/32768 degree units.
	function automatic logic signed [ZW-1:0] atan_of(input logic [3:0] i);
		logic signed [ZW-1:0] v;
		unique case (i)
			4'd0:  v = 24'sd1474560;
			4'd1:  v = 24'sd870484;
			4'd2:  v = 24'sd459940;
			4'd3:  v = 24'sd233473;
			4'd4:  v = 24'sd117189;
			4'd5:  v = 24'sd58652;
			4'd6:  v = 24'sd29333;
			4'd7:  v = 24'sd14667;
			4'd8:  v = 24'sd7334;
			4'd9:  v = 24'sd3667;
			4'd10: v = 24'sd1833;
			4'd11: v = 24'sd917;
			4'd12: v = 24'sd458;
			4'd13: v = 24'sd229;
			4'd14: v = 24'sd115;
			4'd15: v = 24'sd57;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

### hdl/grmc_queue.sv
// Two-entry queue of column results between front end and back end.
// Depends on grmc_pkg.
`default_nettype none

module grmc_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push_valid,
	output logic                    push_ready,
	input  wire grmc_pkg::col_res_t push_data,
	output logic                    pop_valid,
	input  wire logic               pop_ready,
	output grmc_pkg::col_res_t      pop_data
);
	import grmc_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	col_res_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/grmc_front.sv
// Front end: takes a column request, builds the ray direction with an iterative
// rotator, marches the ray one step per cycle and derives the wall height.
// Depends on grmc_pkg.
`default_nettype none

module grmc_front #(
	parameter int MAX_STEPS = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire grmc_pkg::in_t      in_item,
	input  wire grmc_pkg::cfg_t     cfg,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output grmc_pkg::col_res_t      res
);
	import grmc_pkg::*;

	localparam int KW = $clog2(MAX_STEPS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_SUM, S_MOD, S_QUAD, S_ROT, S_DIR, S_MARCH, S_SQX, S_SQY, S_HGT, S_DONE
	} state_t;

	state_t                  state_q;
	in_t                     item_q;
	logic [AW-1:0]           ang_q;
	logic [3:0]              cnt_q;
	logic [1:0]              quad_q;
	logic signed [CW-1:0]    x_q;
	logic signed [CW-1:0]    y_q;
	logic signed [ZW-1:0]    z_q;
	logic signed [PW-1:0]    px_q;
	logic signed [PW-1:0]    py_q;
	logic signed [PW-1:0]    px0_q;
	logic signed [PW-1:0]    py0_q;
	logic signed [CW-1:0]    cs_q;
	logic signed [CW-1:0]    sn_q;
	logic [KW-1:0]           k_q;
	logic [SW-1:0]           acc_q;
	logic [HW-1:0]           h_q;
	logic                    fault_q;

	// Angle sum before reduction.
	logic [15:0]             view_m;
	logic [19:0]             col_prod;
	logic [AW-1:0]           ang_sum;
	logic [AW-1:0]           mod_sub;

	// Rotator step.
	logic signed [CW-1:0]    x_sh;
	logic signed [CW-1:0]    y_sh;
	logic signed [ZW-1:0]    atan_v;

	// March step.
	logic signed [PW-1:0]    nx;
	logic signed [PW-1:0]    ny;
	logic [PW-2-UNIT_SHIFT:0] cx;
	logic [PW-2-UNIT_SHIFT:0] cy;
	logic                    leave;
	logic [6:0]              cell_idx;
	logic                    wall;

	// Distance.
	logic signed [PW-1:0]    diff;
	logic [DW-1:0]           dmag;
	logic [2*DW-1:0]         dsq;

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res.column = item_q.column;
	assign res.height = h_q;
	assign res.fault  = fault_q;

	// Ray angle before reduction modulo a full turn.
	always_comb begin
		view_m   = (item_q.view_angle >= 16'(FULL_TURN)) ?
			item_q.view_angle - 16'(FULL_TURN) : item_q.view_angle;
		col_prod = 20'(item_q.column) * 20'(cfg.angle_step);
		ang_sum  = AW'(view_m) + AW'(col_prod) + AW'(FULL_TURN) - AW'(cfg.half_fov);
		mod_sub  = AW'(FULL_TURN) << cnt_q[2:0];
	end

	// One rotator iteration.
	always_comb begin
		x_sh   = x_q >>> cnt_q;
		y_sh   = y_q >>> cnt_q;
		atan_v = atan_of(cnt_q);
	end

	// One march step and its cell test.
	always_comb begin
		nx       = px_q + {{(PW-CW){cs_q[CW-1]}}, cs_q};
		ny       = py_q + {{(PW-CW){sn_q[CW-1]}}, sn_q};
		cx       = nx[PW-2:UNIT_SHIFT];
		cy       = ny[PW-2:UNIT_SHIFT];
		leave    = nx[PW-1] || ny[PW-1] ||
			(cx >= ($bits(cx))'(MAP_DIM)) || (cy >= ($bits(cy))'(MAP_DIM));
		cell_idx = 7'(cy) * 7'(MAP_DIM) + 7'(cx);
		wall     = leave ? 1'b0 : cfg.map_bits[cell_idx];
	end

	// Squared displacement, one axis per cycle.
	always_comb begin
		diff = (state_q == S_SQX) ? px_q - px0_q : py_q - py0_q;
		dmag = diff[PW-1] ? DW'(-diff) : DW'(diff);
		dsq  = dmag * dmag;
	end

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
			h_q     <= '0;
			fault_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_item;
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					ang_q   <= ang_sum;
					cnt_q   <= 4'd5;
					state_q <= S_MOD;
				end
				// Restoring reduction modulo a full turn, one shifted multiple a cycle.
				S_MOD: begin
					if (ang_q >= mod_sub) begin
						ang_q <= ang_q - mod_sub;
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_QUAD;
					end
				end
				// Quadrant split and rotator start.
				S_QUAD: begin
					if (ang_q >= AW'(3 * QUARTER_TURN)) begin
						quad_q <= 2'd3;
						z_q    <= ZW'({ang_q - AW'(3 * QUARTER_TURN), 8'd0});
					end else if (ang_q >= AW'(2 * QUARTER_TURN)) begin
						quad_q <= 2'd2;
						z_q    <= ZW'({ang_q - AW'(2 * QUARTER_TURN), 8'd0});
					end else if (ang_q >= AW'(QUARTER_TURN)) begin
						quad_q <= 2'd1;
						z_q    <= ZW'({ang_q - AW'(QUARTER_TURN), 8'd0});
					end else begin
						quad_q <= 2'd0;
						z_q    <= ZW'({ang_q, 8'd0});
					end
					x_q     <= CW'(CORDIC_X0);
					y_q     <= '0;
					cnt_q   <= '0;
					state_q <= S_ROT;
				end
				S_ROT: begin
					if (!z_q[ZW-1]) begin
						x_q <= x_q - y_sh;
						y_q <= y_q + x_sh;
						z_q <= z_q - atan_v;
					end else begin
						x_q <= x_q + y_sh;
						y_q <= y_q - x_sh;
						z_q <= z_q + atan_v;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'(CORDIC_ITERS - 1)) begin
						state_q <= S_DIR;
					end
				end
				// Map the rotator output into its quadrant; start the march.
				S_DIR: begin
					unique case (quad_q)
						2'd0: begin cs_q <= x_q;  sn_q <= y_q;  end
						2'd1: begin cs_q <= -y_q; sn_q <= x_q;  end
						2'd2: begin cs_q <= -x_q; sn_q <= -y_q; end
						2'd3: begin cs_q <= y_q;  sn_q <= -x_q; end
					endcase
					px_q    <= PW'({item_q.pos_x, POS_SHIFT'(0)});
					py_q    <= PW'({item_q.pos_y, POS_SHIFT'(0)});
					px0_q   <= PW'({item_q.pos_x, POS_SHIFT'(0)});
					py0_q   <= PW'({item_q.pos_y, POS_SHIFT'(0)});
					k_q     <= '0;
					h_q     <= '0;
					fault_q <= 1'b0;
					state_q <= S_MARCH;
				end
				S_MARCH: begin
					px_q <= nx;
					py_q <= ny;
					k_q  <= k_q + 1'b1;
					if (leave) begin
						fault_q <= 1'b1;
						state_q <= S_DONE;
					end else if (wall) begin
						state_q <= S_SQX;
					end else if (k_q == KW'(MAX_STEPS - 1)) begin
						fault_q <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_SQX: begin
					acc_q   <= SW'(dsq);
					state_q <= S_SQY;
				end
				S_SQY: begin
					acc_q   <= acc_q + SW'(dsq);
					state_q <= S_HGT;
				end
				// Grow the height while the next value still fits the distance.
				S_HGT: begin
					if (h_q == HW'(HALF_ROWS)) begin
						state_q <= S_DONE;
					end else if (acc_q <= HGT_THR[h_q]) begin
						h_q <= h_q + 1'b1;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/grmc_back.sv
// Back end: expands one column result into its screen row items.
// Depends on grmc_pkg.
`default_nettype none

module grmc_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               col_valid,
	output logic                    col_ready,
	input  wire grmc_pkg::col_res_t col,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output grmc_pkg::out_t          out_item
);
	import grmc_pkg::*;

	logic [RW-1:0] row_q;
	logic          valid_q;
	out_t          out_q;
	logic          load;
	logic          last;
	logic [RW-1:0] sky_end;
	logic [RW-1:0] wall_end;
	kind_t         kind;

	assign out_valid = valid_q;
	assign out_item  = out_q;
	assign load      = col_valid && (!valid_q || out_ready);
	assign last      = (row_q == RW'(SCREEN_ROWS - 1));
	assign col_ready = load && last;

	// Row classification against the wall band.
	always_comb begin
		sky_end  = RW'(HALF_ROWS) - RW'(col.height);
		wall_end = RW'(HALF_ROWS) + RW'(col.height);
		if (row_q < sky_end) begin
			kind = KIND_SKY;
		end else if (row_q < wall_end) begin
			kind = KIND_WALL;
		end else begin
			kind = KIND_FLOOR;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_column <= col.column;
			out_q.row        <= row_q;
			out_q.cell_kind  <= kind;
			out_q.last_row   <= last;
			out_q.fault      <= col.fault;
		end
	end

	// Row counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				row_q   <= last ? '0 : row_q + 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/grid_ray_march_column.sv
// Flow: a request passes the angle sum, modulo reduction, quadrant split, rotator and
// one-step-a-cycle ray march (up to MAX_STEPS steps); a wall hit adds the distance and
// height search. A new request is taken only once the last result has entered the queue.
// The 24 row items of a column leave at one per cycle meanwhile, while out_ready is high.
// Reset: arst_n clears control state and loads the power-on map and view registers.
`default_nettype none
`include "grid_ray_march_column_defines.svh"

module grid_ray_march_column #(
	parameter int MAX_STEPS = 1024
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire grmc_pkg::in_t   in_item,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output grmc_pkg::out_t       out_item,
	input  wire logic            psel,
	input  wire logic            penable,
	input  wire logic            pwrite,
	input  wire logic [4:0]      paddr,
	input  wire logic [63:0]     pwdata,
	output logic [63:0]          prdata,
	output logic                 pready
);
	import grmc_pkg::*;

	logic [59:0] map_low_q;
	logic [39:0] map_high_q;
	logic [14:0] half_fov_q;
	logic [12:0] angle_step_q;
	logic [1:0]  reg_idx;
	cfg_t        cfg;
	logic        fr_valid;
	logic        fr_ready;
	col_res_t    fr_res;
	logic        q_valid;
	logic        q_ready;
	col_res_t    q_data;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_low_q    <= 60'd659295305662466047;
			map_high_q   <= 40'd1098976331369;
			half_fov_q   <= 15'd3840;
			angle_step_q <= 13'd98;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_MAP_LOW:    map_low_q    <= pwdata[59:0];
				REG_MAP_HIGH:   map_high_q   <= pwdata[39:0];
				REG_HALF_FOV:   half_fov_q   <= pwdata[14:0];
				REG_ANGLE_STEP: angle_step_q <= pwdata[12:0];
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (reg_idx)
			REG_MAP_LOW:    prdata = 64'(map_low_q);
			REG_MAP_HIGH:   prdata = 64'(map_high_q);
			REG_HALF_FOV:   prdata = 64'(half_fov_q);
			REG_ANGLE_STEP: prdata = 64'(angle_step_q);
		endcase
	end

	assign cfg.map_bits   = {map_high_q, map_low_q};
	assign cfg.half_fov   = half_fov_q;
	assign cfg.angle_step = angle_step_q;

	grmc_front #(
		.MAX_STEPS(MAX_STEPS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.cfg       (cfg),
		.res_valid (fr_valid),
		.res_ready (fr_ready),
		.res       (fr_res)
	);

	grmc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  (fr_res),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	grmc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.col_valid (q_valid),
		.col_ready (q_ready),
		.col       (q_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// The final row flag marks the bottom screen row only.
	`GRMC_ASSERT_IMP(a_last_row, out_valid && out_item.last_row,
		out_item.row == RW'(SCREEN_ROWS - 1))
	// A faulted column draws no wall.
	`GRMC_ASSERT_IMP(a_fault_no_wall, out_valid && out_item.fault,
		out_item.cell_kind != KIND_WALL)
	// Rows of one column follow without gaps.
	`GRMC_ASSERT_NXT(a_rows_burst, out_valid && out_ready && !out_item.last_row,
		out_valid)
	// A column's rows keep the same column index.
	`GRMC_ASSERT_NXT(a_rows_same_col, out_valid && out_ready && !out_item.last_row,
		out_item.out_column == $past(out_item.out_column))

endmodule

`default_nettype wire
